### design/fixed_point_dense_neuron_macros.svh
// Assertion macros used by the neuron design file.
`ifndef FIXED_POINT_DENSE_NEURON_MACROS_SVH
`define FIXED_POINT_DENSE_NEURON_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define FPDN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define FPDN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FPDN_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FPDN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/fpdn_pkg.sv
package fpdn_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned ACC_W   = 64;
	localparam int unsigned OUT_W   = 28;
	localparam int unsigned Q_SHIFT = 20;
	localparam int unsigned QUO_W   = ACC_W - Q_SHIFT;

	// +/-100.0 in Q20
	localparam logic [OUT_W-1:0] CLAMP_MAG = OUT_W'(104857600);

endpackage

### design/fixed_point_dense_neuron.sv
// An accepted last item goes through stage 1 and stage 2 to the neuron_value register.
// Throughput: one weight/activation pair per cycle unless stalled; the accumulate loop
// is one 64-bit add fed by a registered 32x32 product, so pairs stream back to back.
// Input stalls only when a last item waits and both result registers are held.
// Reset (arst_n low, asynchronous): accumulator, valids and relu_q clear to zero.
module fixed_point_dense_neuron (
	input  logic                                clk,
	input  logic                                arst_n,
	// input item channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [fpdn_pkg::DATA_W-1:0] weight,
	input  logic signed [fpdn_pkg::DATA_W-1:0] activation,
	input  logic signed [fpdn_pkg::DATA_W-1:0] bias,
	input  logic                                last,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [fpdn_pkg::OUT_W-1:0]  neuron_value,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                relu_enable
);
	import fpdn_pkg::*;
	`include "fixed_point_dense_neuron_macros.svh"

	// Stage 1: registered product of the accepted pair
	logic                     v_s1;
	logic                     last_s1;
	logic signed [ACC_W-1:0]  prod_s1;
	logic signed [DATA_W-1:0] bias_s1;

	// Stage 2: finished dot product plus bias, waiting for the output stage
	logic                     v_s2;
	logic        [ACC_W-1:0]  sum_s2;

	logic        [ACC_W-1:0]  acc_q;
	logic                     relu_q;
	logic                     out_valid_q;
	logic        [OUT_W-1:0]  out_q;

	logic                     out_load;
	logic                     s2_load;
	logic                     s1_adv;
	logic                     in_take;
	logic        [ACC_W-1:0]  bias_term;
	logic        [ACC_W-1:0]  acc_next;

	// Handshake: the output register loads when empty or being taken; stage 2 frees
	// when it moves on; stage 1 only blocks on a last item with stage 2 still full.
	assign out_load = !out_valid_q || !out_stall;
	assign s2_load  = !v_s2 || out_load;
	assign s1_adv   = !(last_s1 && !s2_load);
	assign in_stall = v_s1 && !s1_adv;
	assign in_take  = in_valid && !in_stall;

	assign cfg_ready = 1'b1;

	// Bias is scaled by 2^20 and folded in on the last transaction only.
	assign bias_term = last_s1 ?
		{{(ACC_W-DATA_W-Q_SHIFT){bias_s1[DATA_W-1]}}, bias_s1, {Q_SHIFT{1'b0}}} :
		'0;
	assign acc_next  = acc_q + prod_s1 + bias_term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relu_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			relu_q <= relu_enable;
		end
	end

	// Stage 1: hold while stalled, otherwise take the next pair or go empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
		end else if (!v_s1 || s1_adv) begin
			v_s1    <= in_take;
			last_s1 <= in_take && last;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			prod_s1 <= weight * activation;
			bias_s1 <= bias;
		end
	end

	// Accumulate; a last transaction hands the sum to stage 2 and clears the accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			v_s2  <= 1'b0;
		end else begin
			if (v_s1 && s1_adv) begin
				acc_q <= last_s1 ? '0 : acc_next;
			end
			if (s2_load) begin
				v_s2 <= v_s1 && s1_adv && last_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && v_s1 && last_s1) begin
			sum_s2 <= acc_next;
		end
	end

	// Output stage: divide by 2^20 toward zero (shift the magnitude), clamp, ReLU.
	logic              sum_neg;
	logic [ACC_W-1:0]  sum_mag;
	logic [QUO_W-1:0]  quo;
	logic [OUT_W-1:0]  quo_sat;
	logic [OUT_W-1:0]  result;

	always_comb begin
		sum_neg = sum_s2[ACC_W-1];
		sum_mag = sum_neg ? (~sum_s2 + ACC_W'(1)) : sum_s2;
		quo     = sum_mag[ACC_W-1:Q_SHIFT];
		quo_sat = (quo > QUO_W'(CLAMP_MAG)) ? CLAMP_MAG : quo[OUT_W-1:0];
		if (sum_neg && (quo_sat != '0)) begin
			result = relu_q ? '0 : (~quo_sat + OUT_W'(1));
		end else begin
			result = quo_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && v_s2) begin
			out_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign neuron_value = out_q;

	// The accumulator starts fresh after every neuron.
	`FPDN_ASSERT_NEXT(a_acc_clear, clk, arst_n, v_s1 && s1_adv && last_s1, acc_q == '0)
	// Results stay inside the +/-100.0 clamp.
	`FPDN_ASSERT_NOW(a_clamp, clk, arst_n, out_valid,
		($signed(neuron_value) <= $signed(CLAMP_MAG)) &&
		($signed(neuron_value) >= -$signed(CLAMP_MAG)))
	// With ReLU on, no negative value leaves the block.
	`FPDN_ASSERT_NOW(a_relu, clk, arst_n, out_valid && relu_q, !neuron_value[OUT_W-1])
	// Input backpressure comes only from a last item blocked behind full result stages.
	`FPDN_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, v_s1 && last_s1 && v_s2 && out_valid_q)

endmodule

### tb/tb_top.sv
module tb_top;

	import fpdn_pkg::*;

	// One weight/activation pair as offered on the input channel.
	typedef struct packed {
		logic signed [DATA_W-1:0] weight;
		logic signed [DATA_W-1:0] activation;
		logic signed [DATA_W-1:0] bias;
		logic                     last;
	} neuron_pair_t;

	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic signed [DATA_W-1:0] weight = '0;
	logic signed [DATA_W-1:0] activation = '0;
	logic signed [DATA_W-1:0] bias = '0;
	logic                     last = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [OUT_W-1:0]  neuron_value;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic                     relu_enable = 1'b0;

	fixed_point_dense_neuron u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.weight       (weight),
		.activation   (activation),
		.bias         (bias),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.neuron_value (neuron_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.relu_enable  (relu_enable)
	);

	always #5 clk = ~clk;

	// Pairs waiting to be offered, and neuron values waiting to come out.
	neuron_pair_t            pending_pairs[$];
	logic signed [OUT_W-1:0] expected_values[$];

	// Shadow of the block: running dot product and the ReLU register.
	logic [ACC_W-1:0] acc_sum = '0;
	logic             relu_on = 1'b0;

	int unsigned send_idle_pct = 33;
	int unsigned recv_idle_pct = 83;
	logic        in_taken = 1'b0;
	logic        hold_armed = 1'b0;
	logic        hold_done = 1'b0;
	int          hold_left = 0;
	int          mismatch_count = 0;
	neuron_pair_t next_pair;

	// Fold one accepted pair into the shadow accumulator; on the last pair
	// add the bias, scale down, clamp, apply ReLU and queue the neuron value.
	function automatic void fold_pair(input neuron_pair_t p);
		logic [ACC_W-1:0] prod;
		logic [ACC_W-1:0] mag;
		logic [ACC_W-1:0] quo;
		logic             negv;
		logic [OUT_W-1:0] value;
		prod = {{32{p.weight[31]}}, p.weight} * {{32{p.activation[31]}}, p.activation};
		acc_sum = acc_sum + prod;
		if (p.last) begin
			acc_sum = acc_sum + {{12{p.bias[31]}}, p.bias, 20'd0};
			negv = acc_sum[ACC_W-1];
			mag = negv ? (~acc_sum + 64'd1) : acc_sum;
			quo = mag >> Q_SHIFT;
			if (quo > {36'd0, CLAMP_MAG})
				quo = {36'd0, CLAMP_MAG};
			// A negative sum that truncates to zero stays zero.
			if (negv && quo != 0)
				value = relu_on ? '0 : (~quo[OUT_W-1:0] + 1'b1);
			else
				value = quo[OUT_W-1:0];
			expected_values.push_back(value);
			acc_sum = '0;
		end
	endfunction

	// Wide mix: mostly moderate Q20 values so sums land inside the clamp,
	// with tiny values, full-range noise and the two extremes mixed in.
	function automatic logic signed [DATA_W-1:0] pick_value();
		logic [31:0] r;
		int unsigned sel;
		r = $urandom;
		sel = $urandom_range(99);
		if (sel < 15)
			r = {{19{r[12]}}, r[12:0]};
		else if (sel < 75)
			r = {{8{r[23]}}, r[23:0]};
		else if (sel >= 96)
			r = r[0] ? 32'h7fff_ffff : 32'h8000_0000;
		return r;
	endfunction

	task automatic push_pair(input logic [31:0] w, a, b, input logic l);
		neuron_pair_t p;
		p.weight = w;
		p.activation = a;
		p.bias = b;
		p.last = l;
		pending_pairs.push_back(p);
	endtask

	// Queue whole neurons with random dot-product lengths until about n pairs.
	task automatic queue_neurons(input int n);
		int count;
		int len;
		count = 0;
		while (count < n) begin
			len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
			for (int k = 0; k < len; k++)
				push_pair(pick_value(), pick_value(), pick_value(), k == len - 1);
			count += len;
		end
	endtask

	// Block until every pair is accepted and every neuron value has come out,
	// then let the pipeline settle so the block is idle for a register write.
	task automatic wait_drained();
		while (pending_pairs.size() != 0 || in_valid || expected_values.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_relu(input logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		relu_enable <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		relu_on = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Driver: advance to the next pair only once the current one is taken;
	// hold the payload steady while it is stalled.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_pair = pending_pairs.pop_front();
				in_valid <= 1'b1;
				weight <= next_pair.weight;
				activation <= next_pair.activation;
				bias <= next_pair.bias;
				last <= next_pair.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off that backs the block up
	// until it stalls its input while the driver keeps offering pairs.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Monitor: sample both channels at the rising edge; check each result
	// transaction against the oldest expectation, then fold in the input.
	always @(posedge clk) begin : watch
		logic signed [OUT_W-1:0] want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_values.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected neuron_value %0d", neuron_value);
				end else begin
					want = expected_values.pop_front();
					if (neuron_value !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("neuron_value mismatch: expected %0d, got %0d",
								want, neuron_value);
					end
				end
			end
			if (in_valid && !in_stall)
				fold_pair({weight, activation, bias, last});
		end
		in_taken <= arst_n && in_valid && !in_stall;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pass with ReLU off and the sender/receiver at 33/83.
		write_relu(1'b0);
		push_pair(32'd0, 32'd0, 32'd0, 1'b1);
		// Non-last pair: its bias must be ignored.
		push_pair(32'h0010_0000, 32'h0030_0000, 32'h7fff_ffff, 1'b0);
		push_pair(32'h0008_0000, -32'sh0010_0000, -32'sh0010_0000, 1'b1);
		// Negative sums: one truncates to -1, one truncates to zero.
		push_pair(-32'sd3, 32'h0008_0000, 32'd0, 1'b1);
		push_pair(-32'sd1, 32'd1, 32'd0, 1'b1);
		// Clamp at both signs from the field extremes.
		push_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		push_pair(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
		// Two min*min products wrap the accumulator to its most negative value.
		push_pair(32'h8000_0000, 32'h8000_0000, 32'd0, 1'b0);
		push_pair(32'h8000_0000, 32'h8000_0000, 32'd0, 1'b0);
		push_pair(32'd0, 32'd0, 32'd0, 1'b1);
		push_pair(32'd0, 32'd0, 32'h8000_0000, 1'b1);
		push_pair(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 1'b1);
		// Exactly at the clamp, and one step beyond on the negative side.
		push_pair(32'd0, 32'd0, 32'd104857600, 1'b1);
		push_pair(32'd0, 32'd0, -32'sd104857601, 1'b1);
		wait_drained();

		// ReLU on: negative results drop to zero, positives pass.
		write_relu(1'b1);
		push_pair(-32'sd3, 32'h0008_0000, 32'd0, 1'b1);
		push_pair(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
		push_pair(32'd0, 32'd0, -32'sd104857601, 1'b1);
		push_pair(32'h0010_0000, 32'h0030_0000, 32'd0, 1'b1);
		queue_neurons(180);
		wait_drained();

		// Swap the idle pattern: sender mostly idle, receiver mostly ready.
		write_relu(1'b0);
		send_idle_pct = 83;
		recv_idle_pct = 33;
		queue_neurons(180);
		wait_drained();

		// Full rate on both sides, with the one long receiver hold-off.
		write_relu(1'b1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_neurons(190);
		hold_armed = 1'b1;
		wait_drained();

		if (mismatch_count == 0 && expected_values.size() == 0)
			$display("PASS fixed_point_dense_neuron");
		else
			$display("FAIL fixed_point_dense_neuron");
		$finish;
	end

	// Hard stop well past the slowest correct run.
	initial begin
		#2000000;
		$display("FAIL fixed_point_dense_neuron");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/fpdn_pkg.sv
design/fixed_point_dense_neuron.sv
tb/tb_top.sv
